// ===== src/rbo_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Rosenbrock objective block.
// No dependencies; every other file in src imports this package.
package rbo_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 12;
  localparam int SUM_WIDTH     = 56;

  // The sum carries twice the fraction bits of a sample.
  localparam int RES_FRAC = 2 * FRACTION_BITS;

  // |1 - p| needs one bit more than a sample; |c - p^2| stays below 2^(2*SW-1).
  localparam int AMAG_W  = SAMPLE_WIDTH + 1;
  localparam int DMAG_W  = 2 * SAMPLE_WIDTH - 1;
  localparam int MUL_W   = (AMAG_W > DMAG_W) ? AMAG_W : DMAG_W;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int AA_W    = 2 * AMAG_W;
  // 100 * d^2 grows by seven bits over d^2.
  localparam int SCALE_W = 2 * DMAG_W + 7;

  localparam logic [SUM_WIDTH-1:0] SUM_MAX    = '1;
  localparam logic [SCALE_W-1:0]   ROUND_HALF = SCALE_W'(1) << (RES_FRAC - 1);
  localparam logic [SAMPLE_WIDTH+1:0] ONE_FIX = (SAMPLE_WIDTH + 2)'(1) << FRACTION_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           is_last;
  } in_item_t;

  typedef struct packed {
    logic [SUM_WIDTH-1:0] objective;
    logic                 saturated;
  } out_item_t;

  // Work handed from the front to the back.
  typedef struct packed {
    logic                    pair;    // a predecessor exists: add one term
    logic                    last;    // emit the sum once this op is done
    logic [AMAG_W-1:0]       amag;    // |1 - p|
    logic [SAMPLE_WIDTH-1:0] pm;      // |p|
    logic [SAMPLE_WIDTH-1:0] sample;  // current element c
  } op_t;

endpackage

// ===== src/rosenbrock_objective.sv =====
`timescale 1ns / 1ps
// Top level of the Rosenbrock objective block: front end, op queue, back end.
// Uses rbo_pkg, rbo_front, rbo_queue and rbo_back.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_item_t  (sample, is_last)
//   out_     output     out_valid/out_stall out_item_t (objective, saturated)
//
// In the back end an element with a predecessor passes through DMAG, DSQ, SCALE
// and ACC: three squares share one multiplier, then the scaled term is formed,
// and its accumulation overlaps the first square of the next element.
// The first element of a vector stays in the front end, unless it is also the last.
// Reset (synchronous, active low) clears the predecessor, the sum and the queue.
// A stalled output holds its transaction; the queue lets input continue until full.
module rosenbrock_objective
  import rbo_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic push;
  op_t  push_op;
  logic pop;
  logic q_full;
  logic q_empty;
  op_t  q_head;

  rbo_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  rbo_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  rbo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/rbo_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts elements, tracks the predecessor and classifies each one.
// Uses rbo_pkg; feeds rbo_queue.
module rbo_front
  import rbo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output op_t      push_op
);

  logic [SAMPLE_WIDTH-1:0]   prev_r, prev_nxt;
  logic                      have_r, have_nxt;
  logic                      accept;
  logic signed [SAMPLE_WIDTH+1:0] one_m_p;
  logic signed [SAMPLE_WIDTH+1:0] one_m_p_neg;
  logic signed [SAMPLE_WIDTH:0]   p_ext;
  logic signed [SAMPLE_WIDTH:0]   p_neg;

  always_comb begin
    in_stall = q_full;
    accept   = in_valid & ~q_full;

    one_m_p     = $signed(ONE_FIX) - $signed({{2{prev_r[SAMPLE_WIDTH-1]}}, prev_r});
    one_m_p_neg = -one_m_p;
    p_ext       = $signed({prev_r[SAMPLE_WIDTH-1], prev_r});
    p_neg       = -p_ext;

    push_op.pair   = have_r;
    push_op.last   = in_data.is_last;
    push_op.amag   = one_m_p[SAMPLE_WIDTH+1] ? one_m_p_neg[AMAG_W-1:0]
                                             : one_m_p[AMAG_W-1:0];
    push_op.pm     = prev_r[SAMPLE_WIDTH-1] ? p_neg[SAMPLE_WIDTH-1:0]
                                            : p_ext[SAMPLE_WIDTH-1:0];
    push_op.sample = in_data.sample;

    // The first element of a vector only becomes the predecessor, unless it
    // is also the last one, in which case the back end must still emit.
    push = accept & (have_r | in_data.is_last);

    prev_nxt = prev_r;
    have_nxt = have_r;
    if (accept) begin
      if (in_data.is_last) begin
        prev_nxt = '0;
        have_nxt = 1'b0;
      end else begin
        prev_nxt = in_data.sample;
        have_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      have_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      have_r <= have_nxt;
    end
  end

endmodule

// ===== src/rbo_queue.sv =====
`timescale 1ns / 1ps
// Short first-in first-out queue of ops between the front and back ends.
// Uses rbo_pkg; the depth is a power of two so the pointers wrap freely.
module rbo_queue
  import rbo_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic full,
  output logic empty,
  output op_t  head
);

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    full  = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
    empty = (count_r == '0);
    head  = mem_r[rd_ptr_r];

    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/rbo_back.sv =====
`timescale 1ns / 1ps
// Back end: one shared squaring multiplier, scaling, saturating accumulation
// and the output register. Uses rbo_pkg; fed by rbo_queue.
module rbo_back
  import rbo_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  op_t       q_head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DMAG  = 3'd1;
  localparam logic [2:0] ST_DSQ   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;

  logic [2:0]           state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [PROD_W-1:0]    mul_r, mul_nxt;
  logic [DMAG_W-1:0]    dmag_r, dmag_nxt;
  logic [SUM_WIDTH-1:0] term_r, term_nxt;
  logic                 term_sat_r, term_sat_nxt;
  logic [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [MUL_W-1:0]     mul_in;
  logic [PROD_W-1:0]    prod;
  logic                 slot_free;
  logic                 load_next;
  logic signed [DMAG_W:0] cs;
  logic signed [DMAG_W:0] diff;
  logic signed [DMAG_W:0] diff_neg;
  logic [SCALE_W-1:0]   sq_ext;
  logic [SCALE_W-1:0]   scaled;
  logic [SCALE_W-1:0]   term_wide;
  logic [SUM_WIDTH:0]   aa_sum;
  logic [SUM_WIDTH:0]   t_sum;
  logic [SUM_WIDTH-1:0] final_sum;
  logic                 final_ovf;

  assign prod = PROD_W'(mul_in) * PROD_W'(mul_in);

  always_comb begin
    slot_free = ~out_valid_r | ~out_stall;
    load_next = ~q_empty & q_head.pair;

    // c shifted to 2F fraction bits, minus p^2 from the first square.
    cs       = $signed({{(DMAG_W + 1 - SAMPLE_WIDTH){op_r.sample[SAMPLE_WIDTH-1]}},
                        op_r.sample}) <<< FRACTION_BITS;
    diff     = cs - $signed({1'b0, mul_r[DMAG_W-1:0]});
    diff_neg = -diff;

    // 100 = 64 + 32 + 4, with half an output step added for rounding.
    sq_ext    = SCALE_W'(mul_r);
    scaled    = (sq_ext << 6) + (sq_ext << 5) + (sq_ext << 2) + ROUND_HALF;
    term_wide = scaled >> RES_FRAC;

    aa_sum = {1'b0, sum_r} + (SUM_WIDTH + 1)'(mul_r[AA_W-1:0]);
    t_sum  = {1'b0, sum_r} + {1'b0, term_r};
    if (term_sat_r || t_sum[SUM_WIDTH]) begin
      final_sum = SUM_MAX;
      final_ovf = 1'b1;
    end else begin
      final_sum = t_sum[SUM_WIDTH-1:0];
      final_ovf = ovf_r;
    end

    state_nxt     = state_r;
    op_nxt        = op_r;
    mul_nxt       = mul_r;
    dmag_nxt      = dmag_r;
    term_nxt      = term_r;
    term_sat_nxt  = term_sat_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    mul_in        = '0;

    case (state_r)
      ST_IDLE: begin
        if (load_next) begin
          mul_in    = MUL_W'(q_head.pm);
          mul_nxt   = prod;
          op_nxt    = q_head;
          pop       = 1'b1;
          state_nxt = ST_DMAG;
        end else if (!q_empty && slot_free) begin
          // Last element with no predecessor: emit the sum as it stands.
          out_valid_nxt          = 1'b1;
          out_data_nxt.objective = sum_r;
          out_data_nxt.saturated = ovf_r;
          sum_nxt                = '0;
          ovf_nxt                = 1'b0;
          pop                    = 1'b1;
        end
      end
      ST_DMAG: begin
        dmag_nxt  = diff[DMAG_W] ? diff_neg[DMAG_W-1:0] : diff[DMAG_W-1:0];
        mul_in    = MUL_W'(op_r.amag);
        mul_nxt   = prod;
        state_nxt = ST_DSQ;
      end
      ST_DSQ: begin
        mul_in  = MUL_W'(dmag_r);
        mul_nxt = prod;
        if (aa_sum[SUM_WIDTH]) begin
          sum_nxt = SUM_MAX;
          ovf_nxt = 1'b1;
        end else begin
          sum_nxt = aa_sum[SUM_WIDTH-1:0];
        end
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        term_sat_nxt = term_wide > {{(SCALE_W - SUM_WIDTH){1'b0}}, SUM_MAX};
        term_nxt     = term_wide[SUM_WIDTH-1:0];
        state_nxt    = ST_ACC;
      end
      ST_ACC: begin
        if (!op_r.last || slot_free) begin
          if (op_r.last) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.objective = final_sum;
            out_data_nxt.saturated = final_ovf;
            sum_nxt                = '0;
            ovf_nxt                = 1'b0;
          end else begin
            sum_nxt = final_sum;
            ovf_nxt = final_ovf;
          end
          // The multiplier is free here, so the next op starts at once.
          if (load_next) begin
            mul_in    = MUL_W'(q_head.pm);
            mul_nxt   = prod;
            op_nxt    = q_head;
            pop       = 1'b1;
            state_nxt = ST_DMAG;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mul_r      <= mul_nxt;
    dmag_r     <= dmag_nxt;
    term_r     <= term_nxt;
    term_sat_r <= term_sat_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/rbo_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the Rosenbrock objective block, bound to its top level.
// Uses rbo_pkg; watches the ports of rosenbrock_objective only.
module rbo_checker
  import rbo_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic [3:0] pending_r, pending_nxt;
  logic       in_last_acc;
  logic       out_acc;

  always_comb begin
    in_last_acc = in_valid & ~in_stall & in_data.is_last;
    out_acc     = out_valid & ~out_stall;
    pending_nxt = pending_r + {3'b000, in_last_acc} - {3'b000, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // No result goes out before reset has released the output register.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // Every result must answer a vector whose last element was taken.
  a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result without an accepted last element");

  // Once clamped the sum stays at its largest value.
  a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> &out_data.objective)
    else $error("saturated result below the maximum");

endmodule

bind rosenbrock_objective rbo_checker u_rbo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
